[rtl/amjq_pkg.sv]
// Shared types and constants for the ancestor minimum jump query block.
// No dependencies; imported by amjq_engine and ancestor_min_jump_query.
package amjq_pkg;

   localparam int CMD_W  = 2;
   localparam int NODE_W = 10;
   localparam int VAL_W  = 32;
   localparam int CSR_W  = 11;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [VAL_W-1:0] ROOT_VALUE = 32'd1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] parent;
      logic [VAL_W-1:0]  value;
      logic [VAL_W-1:0]  threshold;
   } req_type;

endpackage

[rtl/amjq_engine.sv]
// Sequencer and storage: lifting table memory (ancestor, valid, path minimum)
// and node value memory, both with registered reads. Uses amjq_pkg.
module amjq_engine import amjq_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  req_type                     in_req,
   input  logic [$clog2(LEVELS+1)-1:0] lv,
   input  logic [CSR_W-1:0]            nodes,
   output logic                        res_valid,
   input  logic                        res_ready,
   output logic [NODE_W-1:0]           res_node
);

   localparam int NW    = $clog2(MAX_NODES);
   localparam int LW    = $clog2(LEVELS);
   localparam int LVW   = $clog2(LEVELS+1);
   localparam int AW    = NW + LW;
   localparam int DEPTH = MAX_NODES << LW;

   typedef struct packed {
      logic          valid;
      logic [NW-1:0] idx;
      logic [VAL_W-1:0] pm;
   } lift_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_B_RDA, ST_B_WTA, ST_B_WTB, ST_Q_STEP, ST_DONE
   } state_type;

   function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   lift_type         lift_mem [DEPTH];
   logic [VAL_W-1:0] val_mem  [MAX_NODES];

   lift_type         lift_rd_ff;
   logic [VAL_W-1:0] val_rd_ff;

   logic             lift_we, lift_re, val_we, val_re;
   logic [AW-1:0]    lift_waddr, lift_raddr;
   lift_type         lift_wdata;
   logic [NW-1:0]    val_waddr, val_raddr;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W-1:0] parent_ff, parent_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [VAL_W-1:0]  thr_ff, thr_in;
   logic [NW-1:0]     r_ff, r_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [NW-1:0]     bi_ff, bi_in;
   logic              jumped_ff, jumped_in;
   logic [NW-1:0]     round_ff, round_in;
   logic [VAL_W-1:0]  apm_ff, apm_in;
   logic [NODE_W-1:0] ans_ff, ans_in;

   logic             last_node, last_lvl, take, jump_any;
   logic [NW-1:0]    r_next;
   logic [VAL_W-1:0] parent_val;

   always_ff @(posedge clock) begin
      if (lift_we) lift_mem[lift_waddr] <= lift_wdata;
      if (lift_re) lift_rd_ff <= lift_mem[lift_raddr];
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_waddr] <= value_ff;
      if (val_re) val_rd_ff <= val_mem[val_raddr];
   end

   assign last_node = (32'(bi_ff) + 32'd1) == 32'(nodes);
   assign last_lvl  = (LVW'(lvl_ff) + LVW'(1)) == lv;
   assign take      = lift_rd_ff.valid && (lift_rd_ff.pm >= thr_ff);
   assign r_next    = take ? lift_rd_ff.idx : r_ff;
   assign jump_any  = jumped_ff | take;

   always_comb begin
      if (parent_ff == '0)
         parent_val = ROOT_VALUE;
      else if (parent_ff == node_ff)
         parent_val = value_ff;
      else
         parent_val = val_rd_ff;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_node  = ans_ff;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      node_in    = node_ff;
      parent_in  = parent_ff;
      value_in   = value_ff;
      thr_in     = thr_ff;
      r_in       = r_ff;
      lvl_in     = lvl_ff;
      bi_in      = bi_ff;
      jumped_in  = jumped_ff;
      round_in   = round_ff;
      apm_in     = apm_ff;
      ans_in     = ans_ff;
      lift_we    = 1'b0;
      lift_waddr = clr_ff;
      lift_wdata = '0;
      lift_re    = 1'b0;
      lift_raddr = '0;
      val_we     = 1'b0;
      val_waddr  = NW'(node_ff);
      val_re     = 1'b0;
      val_raddr  = NW'(in_req.parent);

      case (state_ff)
         ST_CLEAR: begin
            lift_we = 1'b1;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (in_valid) begin
               node_in   = in_req.node;
               parent_in = in_req.parent;
               value_in  = in_req.value;
               thr_in    = in_req.threshold;
               case (in_req.cmd)
                  CMD_LOAD: begin
                     if (in_req.node != '0 && 32'(in_req.node) < MAX_NODES
                         && 32'(in_req.parent) < MAX_NODES) begin
                        val_re   = 1'b1;
                        state_in = ST_LOAD;
                     end
                  end
                  CMD_BUILD: begin
                     if (lv > LVW'(1) && nodes != '0) begin
                        lvl_in   = LW'(1);
                        bi_in    = '0;
                        state_in = ST_B_RDA;
                     end
                  end
                  CMD_QUERY: begin
                     if (32'(in_req.node) >= MAX_NODES || lv == '0) begin
                        ans_in   = in_req.node;
                        state_in = ST_DONE;
                     end else begin
                        r_in       = NW'(in_req.node);
                        lvl_in     = '0;
                        jumped_in  = 1'b0;
                        round_in   = '0;
                        lift_re    = 1'b1;
                        lift_raddr = {NW'(in_req.node), LW'(0)};
                        state_in   = ST_Q_STEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            lift_we    = 1'b1;
            lift_waddr = {NW'(node_ff), LW'(0)};
            lift_wdata = '{valid: 1'b1, idx: NW'(parent_ff),
                           pm: min_val(value_ff, parent_val)};
            val_we     = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_B_RDA: begin
            lift_re    = 1'b1;
            lift_raddr = {bi_ff, LW'(lvl_ff - LW'(1))};
            state_in   = ST_B_WTA;
         end
         ST_B_WTA, ST_B_WTB: begin
            if (state_ff == ST_B_WTA && lift_rd_ff.valid) begin
               apm_in     = lift_rd_ff.pm;
               lift_re    = 1'b1;
               lift_raddr = {lift_rd_ff.idx, LW'(lvl_ff - LW'(1))};
               state_in   = ST_B_WTB;
            end else begin
               if (state_ff == ST_B_WTB) begin
                  lift_we    = 1'b1;
                  lift_waddr = {bi_ff, lvl_ff};
                  lift_wdata = '{valid: lift_rd_ff.valid, idx: lift_rd_ff.idx,
                                 pm: min_val(apm_ff, lift_rd_ff.pm)};
               end
               if (last_node) begin
                  if (LVW'(lvl_ff) + LVW'(1) == lv) begin
                     state_in = ST_IDLE;
                  end else begin
                     lvl_in   = lvl_ff + LW'(1);
                     bi_in    = '0;
                     state_in = ST_B_RDA;
                  end
               end else begin
                  bi_in    = bi_ff + NW'(1);
                  state_in = ST_B_RDA;
               end
            end
         end
         ST_Q_STEP: begin
            r_in = r_next;
            if (last_lvl) begin
               if (!jump_any || round_ff == NW'(MAX_NODES-1)) begin
                  ans_in   = NODE_W'(r_next);
                  state_in = ST_DONE;
               end else begin
                  round_in   = round_ff + NW'(1);
                  lvl_in     = '0;
                  jumped_in  = 1'b0;
                  lift_re    = 1'b1;
                  lift_raddr = {r_next, LW'(0)};
               end
            end else begin
               lvl_in     = lvl_ff + LW'(1);
               jumped_in  = jump_any;
               lift_re    = 1'b1;
               lift_raddr = {r_next, LW'(lvl_ff + LW'(1))};
            end
         end
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      node_ff   <= node_in;
      parent_ff <= parent_in;
      value_ff  <= value_in;
      thr_ff    <= thr_in;
      r_ff      <= r_in;
      lvl_ff    <= lvl_in;
      bi_ff     <= bi_in;
      jumped_ff <= jumped_in;
      round_ff  <= round_in;
      apm_ff    <= apm_in;
      ans_ff    <= ans_in;
   end

endmodule

[rtl/ancestor_min_jump_query.sv]
// Top level of the ancestor minimum jump query block: node_count register,
// result register and the table engine. Uses amjq_pkg and amjq_engine.
//
// Requests (req_*) carry cmd, node, parent, value and threshold. A load
// (cmd 0) reads the parent value, then writes level 0 and the node value;
// it is dropped for node 0 or an out-of-range node or parent. A build
// (cmd 1) reads, per node and level above 0, the entry one level down and,
// if it is valid, the entry it points to. A query (cmd 2) runs rounds over
// the levels, one table read per level tried. Cmd 3 is taken and does
// nothing. One request is in work at a time, paced by the single read port
// of the lifting table. A query answer appears on rsp_answer_node from a
// result register, so the next request is taken while an answer waits; if
// rsp_ready stays low, a second answer holds the engine until the register drains.
// csr_data writes node_count (reset 1) and is always taken; it sets the
// levels in use and the node range of a build. After reset the lifting
// table of MAX_NODES * 2**clog2(LEVELS) entries (16384 by default) is
// cleared one entry a cycle; req_ready stays low until it is done.
module ancestor_min_jump_query import amjq_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [NODE_W-1:0] req_node,
   input  logic [NODE_W-1:0] req_parent,
   input  logic [VAL_W-1:0]  req_value,
   input  logic [VAL_W-1:0]  req_threshold,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [NODE_W-1:0] rsp_answer_node,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_data
);

   localparam int LVW = $clog2(LEVELS+1);

   logic [LVW-1:0]    lv_ff, lv_in;
   logic [CSR_W-1:0]  n_ff, n_in;
   logic              rsp_valid_ff;
   logic [NODE_W-1:0] rsp_node_ff;
   req_type           req;
   logic              res_valid, res_ready;
   logic [NODE_W-1:0] res_node;

   assign csr_ready = 1'b1;

   always_comb begin
      lv_in = '0;
      for (int j = 0; j < LEVELS; j++) begin
         if (32'(csr_data) >= (32'd1 << j)) lv_in = LVW'(j + 1);
      end
      n_in = (32'(csr_data) > MAX_NODES) ? CSR_W'(MAX_NODES) : csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= LVW'(1);
         n_ff  <= CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         lv_ff <= lv_in;
         n_ff  <= n_in;
      end
   end

   assign req = '{cmd: req_cmd, node: req_node, parent: req_parent,
                  value: req_value, threshold: req_threshold};

   assign res_ready = !rsp_valid_ff || rsp_ready;

   amjq_engine #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_req    (req),
      .lv        (lv_ff),
      .nodes     (n_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_node  (res_node)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && res_ready) rsp_node_ff <= res_node;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_answer_node = rsp_node_ff;

endmodule
